### rtl/lcfe_pkg.sv
// ----------------------------------------------------------------------------
// lcfe_pkg
// Shared types and constants for the LRU key store with first-eviction marks.
// ----------------------------------------------------------------------------
package lcfe_pkg;

	localparam int STEP_W = 32;
	localparam int SIZE_W = 5;
	localparam int SIZE_RESET = 16;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [SIZE_W-1:0] size_cfg_t;

	localparam step_t STEP_MAX = '1;

endpackage

### rtl/lcfe_if.sv
// ----------------------------------------------------------------------------
// lcfe_if
// Valid/ready channels for requests and results of the LRU key store.
// ----------------------------------------------------------------------------
interface lcfe_req_if #(
	parameter int KEY_BITS = 16
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] request_key;

	modport source (output valid, output request_key, input ready);
	modport sink (input valid, input request_key, output ready);
endinterface

interface lcfe_res_if
	import lcfe_pkg::*;
#(
	parameter int KEY_BITS = 16
);
	logic                valid;
	logic                ready;
	logic                hit;
	logic                evicted_valid;
	logic [KEY_BITS-1:0] evicted_key;
	logic                first_eviction;
	step_t               step_number;

	modport source (output valid, output hit, output evicted_valid, output evicted_key,
		output first_eviction, output step_number, input ready);
	modport sink (input valid, input hit, input evicted_valid, input evicted_key,
		input first_eviction, input step_number, output ready);
endinterface

### rtl/lcfe_ram.sv
// ----------------------------------------------------------------------------
// lcfe_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lcfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/lcfe_engine.sv
// ----------------------------------------------------------------------------
// lcfe_engine
// Sequencer for the recency list: streaming move-to-front over the list RAM,
// first-eviction flag read-modify-write, reload sweep and result register.
// ----------------------------------------------------------------------------
module lcfe_engine
	import lcfe_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS = 16,
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             reload,
	input  logic [CNT_W-1:0] size,
	lcfe_req_if.sink         req,
	lcfe_res_if.source       res
);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_FLAG, S_DONE} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	state_t              state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] carry_q;
	logic [KEY_BITS-1:0] victim_q;
	logic                hit_q;
	logic                first_q;
	step_t               step_q;

	logic                out_valid_q;
	logic                out_hit_q;
	logic                out_evv_q;
	logic [KEY_BITS-1:0] out_evk_q;
	logic                out_first_q;
	step_t               out_step_q;

	logic                list_we;
	logic [IDX_W-1:0]    list_raddr;
	logic [KEY_BITS-1:0] list_wdata;
	logic [KEY_BITS-1:0] list_rdata;
	logic                flag_we;
	logic [IDX_W-1:0]    flag_waddr;
	logic [IDX_W-1:0]    flag_raddr;
	logic                flag_wdata;
	logic                flag_rdata;

	logic [IDX_W-1:0]    last_idx;
	logic                match;
	logic                is_last;
	logic                victim_in;
	logic                first_now;
	logic                out_free;
	logic                out_load;
	logic                accept;

	assign last_idx  = IDX_W'(size - CNT_W'(1));
	assign match     = (list_rdata == key_q);
	assign is_last   = (idx_q == last_idx);
	assign victim_in = (33'(victim_q) >= 33'd1) && (33'(victim_q) <= 33'(size));
	assign first_now = victim_in && !flag_rdata;
	assign out_free  = !out_valid_q || res.ready;
	assign out_load  = !reload && (state_q == S_DONE) && out_free;
	assign accept    = req.valid && req.ready;

	assign req.ready = (state_q == S_IDLE) && !reload;

	// list port: reload sweep writes keys 1..size, scan writes the carried key back
	always_comb begin
		list_we    = 1'b0;
		list_wdata = carry_q;
		case (state_q)
			S_CLEAR: begin
				list_we    = 1'b1;
				list_wdata = (32'(idx_q) < 32'(size)) ? KEY_BITS'(32'(idx_q) + 32'd1) : '0;
			end
			S_SCAN: begin
				list_we = 1'b1;
			end
			default: begin
				list_we = 1'b0;
			end
		endcase
	end

	// read one position ahead of the one whose data returns this cycle
	assign list_raddr = (state_q == S_IDLE) ? '0 : idx_q + IDX_W'(1);

	// flag read is addressed straight from the victim as it leaves the list RAM
	assign flag_raddr = IDX_W'(list_rdata - KEY_BITS'(1));
	assign flag_we    = (state_q == S_CLEAR) || ((state_q == S_FLAG) && first_now);
	assign flag_waddr = (state_q == S_CLEAR) ? idx_q : IDX_W'(victim_q - KEY_BITS'(1));
	assign flag_wdata = (state_q != S_CLEAR);

	lcfe_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (MAX_ENTRIES)
	) u_list_ram (
		.clk   (clk),
		.we    (list_we),
		.waddr (idx_q),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

	lcfe_ram #(
		.WIDTH (1),
		.DEPTH (MAX_ENTRIES)
	) u_flag_ram (
		.clk   (clk),
		.we    (flag_we),
		.waddr (flag_waddr),
		.wdata (flag_wdata),
		.raddr (flag_raddr),
		.rdata (flag_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			key_q       <= '0;
			carry_q     <= '0;
			victim_q    <= '0;
			hit_q       <= 1'b0;
			first_q     <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			out_hit_q   <= 1'b0;
			out_evv_q   <= 1'b0;
			out_evk_q   <= '0;
			out_first_q <= 1'b0;
			out_step_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (reload) begin
				state_q <= S_CLEAR;
				idx_q   <= '0;
				step_q  <= '0;
			end else begin
				case (state_q)
					S_CLEAR: begin
						if (idx_q == LAST_IDX) begin
							idx_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					S_IDLE: begin
						if (accept) begin
							key_q    <= req.request_key;
							carry_q  <= req.request_key;
							victim_q <= '0;
							hit_q    <= 1'b0;
							first_q  <= 1'b0;
							idx_q    <= '0;
							if (step_q != STEP_MAX) begin
								step_q <= step_q + step_t'(1);
							end
							state_q <= S_SCAN;
						end
					end
					S_SCAN: begin
						carry_q <= list_rdata;
						if (match) begin
							hit_q   <= 1'b1;
							state_q <= S_DONE;
						end else if (is_last) begin
							victim_q <= list_rdata;
							state_q  <= S_FLAG;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					S_FLAG: begin
						first_q <= first_now;
						state_q <= S_DONE;
					end
					S_DONE: begin
						if (out_free) begin
							out_hit_q   <= hit_q;
							out_evv_q   <= !hit_q;
							out_evk_q   <= victim_q;
							out_first_q <= first_q;
							out_step_q  <= step_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign res.valid          = out_valid_q;
	assign res.hit            = out_hit_q;
	assign res.evicted_valid  = out_evv_q;
	assign res.evicted_key    = out_evk_q;
	assign res.first_eviction = out_first_q;
	assign res.step_number    = out_step_q;

endmodule

### rtl/lru_cache_first_eviction.sv
// ----------------------------------------------------------------------------
// lru_cache_first_eviction
// Fully associative LRU key store with move-to-front replacement and
// first-eviction tracking of the keys loaded at reload.
// ----------------------------------------------------------------------------
// Keys are held in recency order in a list RAM, front at address 0. A request
// walks the list one position per cycle, shifting each key back by one until
// the requested key is found (hit at position p) or the last in-use entry is
// reached (miss). A miss also does a read-modify-write of the first-eviction
// flag RAM. After reset and after every write to the size register the block
// sweeps all MAX_ENTRIES entries of both RAMs, reloading keys 1..size and
// clearing the flags and step count; no request is taken during the sweep. A
// result waits in an output register while the next request is taken.
module lru_cache_first_eviction
	import lcfe_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int KEY_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  size_cfg_t  cfg_wdata,
	lcfe_req_if.sink   req,
	lcfe_res_if.source res
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [CNT_W-1:0] RESET_SIZE =
		CNT_W'((SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : SIZE_RESET);

	logic [CNT_W-1:0] size_q;
	logic             reload_q;
	logic [CNT_W-1:0] size_clamped;

	// zero reads as one, anything above the store depth saturates
	always_comb begin
		if (cfg_wdata == '0) begin
			size_clamped = CNT_W'(1);
		end else if (32'(cfg_wdata) > 32'(MAX_ENTRIES)) begin
			size_clamped = CNT_W'(MAX_ENTRIES);
		end else begin
			size_clamped = CNT_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= RESET_SIZE;
			reload_q <= 1'b0;
		end else begin
			reload_q <= cfg_we;
			if (cfg_we) begin
				size_q <= size_clamped;
			end
		end
	end

	lcfe_engine #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.KEY_BITS    (KEY_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.reload (reload_q),
		.size   (size_q),
		.req    (req),
		.res    (res)
	);

endmodule

### rtl/lcfe_checker.sv
// ----------------------------------------------------------------------------
// lcfe_checker
// Port-level assertions for the LRU key store, bound to the top level.
// ----------------------------------------------------------------------------
module lcfe_checker
	import lcfe_pkg::*;
#(
	parameter int KEY_BITS = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_we,
	input logic                req_ready,
	input logic                res_valid,
	input logic                res_ready,
	input logic                res_hit,
	input logic                res_evicted_valid,
	input logic [KEY_BITS-1:0] res_evicted_key,
	input logic                res_first_eviction,
	input step_t               res_step_number
);

	// a stalled result transaction keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable({res_hit, res_evicted_valid,
			res_evicted_key, res_first_eviction, res_step_number}))
		else $error("result changed while stalled");

	a_hit_xor_evict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_hit != res_evicted_valid)
		else $error("hit and eviction flags disagree");

	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_hit |-> res_evicted_key == '0 && !res_first_eviction)
		else $error("hit reports an eviction");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_step_number != '0)
		else $error("step number zero");

	// reload must block requests until the sweep is under way
	a_reload_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !req_ready)
		else $error("request taken during reload");

endmodule

bind lru_cache_first_eviction lcfe_checker #(
	.KEY_BITS (KEY_BITS)
) u_lcfe_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.cfg_we             (cfg_we),
	.req_ready          (req.ready),
	.res_valid          (res.valid),
	.res_ready          (res.ready),
	.res_hit            (res.hit),
	.res_evicted_valid  (res.evicted_valid),
	.res_evicted_key    (res.evicted_key),
	.res_first_eviction (res.first_eviction),
	.res_step_number    (res.step_number)
);
